FILE: rtl/modexp_pkg.sv
// ============================================================================
// Modular exponentiation package
// Types, constants and the microcode table shared by the sequencer, the
// modular multiplier and the top level.
// ============================================================================
`default_nettype none

package modexp_pkg;

    // Prime modulus and the exponent used for the Fermat inverse.
    localparam logic [29:0] MODULUS      = 30'd1000000007;
    localparam logic [31:0] MODULUS_X2   = 32'd2000000014;
    localparam logic [62:0] INV_EXPONENT = 63'(MODULUS) - 63'd2;

    // Barrett constant: floor(2^60 / MODULUS), fits in 31 bits.
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(MODULUS));

    // Step counter of the sequencer.
    typedef logic [2:0] t_step;

    localparam t_step STEP_LOAD = 3'd0;
    localparam t_step STEP_MUL  = 3'd1;
    localparam t_step STEP_SQR  = 3'd2;
    localparam t_step STEP_WAIT = 3'd3;
    localparam t_step STEP_PUT  = 3'd4;

    // Datapath operation of one control word.
    typedef enum logic [2:0] {
        U_NOP,
        U_LOAD,
        U_MUL,
        U_SQR,
        U_PUT
    } t_uop;

    // Condition that holds the sequencer on its current step.
    typedef enum logic [1:0] {
        H_NONE,
        H_INPUT,
        H_BUSY,
        H_OUTPUT
    } t_hold;

    // Branch condition of one control word.
    typedef enum logic [1:0] {
        C_NEXT,
        C_JUMP,
        C_EXP_ZERO
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_hold hold_on;
        t_cond cond;
        t_step target;
    } t_ucode;

    // Destination register of a modular multiplication.
    typedef enum logic {
        D_ACC,
        D_SQ
    } t_dest;

    // Request into and response from the modular multiplier.
    typedef struct packed {
        logic  start;
        t_dest dest;
    } t_mm_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_dest dest;
    } t_mm_rsp;

    // Status seen by the sequencer and strobes it drives.
    typedef struct packed {
        logic in_valid;
        logic busy;
        logic exp_zero;
        logic out_free;
    } t_seq_stat;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic issue_mul;
        logic issue_sqr;
        logic put;
    } t_seq_ctrl;

    // Microcode table: one control word per step.
    function automatic t_ucode ucode_rom(input t_step step);
        t_ucode cw;
        cw = '{op: U_NOP, hold_on: H_NONE, cond: C_JUMP, target: STEP_LOAD};
        case (step)
            STEP_LOAD: cw = '{op: U_LOAD, hold_on: H_INPUT,  cond: C_NEXT,
                              target: STEP_LOAD};
            STEP_MUL:  cw = '{op: U_MUL,  hold_on: H_NONE,   cond: C_EXP_ZERO,
                              target: STEP_PUT};
            STEP_SQR:  cw = '{op: U_SQR,  hold_on: H_NONE,   cond: C_NEXT,
                              target: STEP_LOAD};
            STEP_WAIT: cw = '{op: U_NOP,  hold_on: H_BUSY,   cond: C_JUMP,
                              target: STEP_MUL};
            STEP_PUT:  cw = '{op: U_PUT,  hold_on: H_OUTPUT, cond: C_JUMP,
                              target: STEP_LOAD};
            default:   cw = '{op: U_NOP,  hold_on: H_NONE,   cond: C_JUMP,
                              target: STEP_LOAD};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/modular_exponentiation.sv
// ============================================================================
// Modular exponentiation
// Base to a 63-bit power modulo 1000000007 by right-to-left square and
// multiply, with a Fermat inverse mode.
// ============================================================================
// One request is taken at a time. The loop runs over the exponent bits up
// to and including the highest set one (none for a zero exponent, 30 in
// invert mode). Each exponent bit costs one pass through the four-stage
// modular multiplier, into which the multiply (only for a set bit) and the
// square are issued on consecutive cycles; the sequencer waits for both to
// retire before the next bit. The next request is accepted once the result
// sits in the output register, even while that result is still stalled.
// An exponent of zero gives 1; the inverse of zero gives 0.
`default_nettype none

module modular_exponentiation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [29:0] i_base,
    input  wire logic [62:0] i_exponent,
    input  wire logic        i_invert,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [29:0]      o_power_result
);
    import modexp_pkg::*;

    logic [29:0] r_acc;
    logic [29:0] r_sq;
    logic [62:0] r_exp;
    logic        r_out_valid;
    logic [29:0] r_power_result;

    t_seq_stat   w_stat;
    t_seq_ctrl   w_ctrl;
    t_mm_req     w_mm_req;
    t_mm_rsp     w_mm_rsp;
    logic [29:0] w_mm_a;
    logic [29:0] w_mm_result;
    logic [30:0] w_base_diff;
    logic [29:0] w_base_red;

    // Sequencer.
    assign w_stat.in_valid = i_valid;
    assign w_stat.busy     = w_mm_rsp.busy;
    assign w_stat.exp_zero = (r_exp == '0);
    assign w_stat.out_free = !r_out_valid || !i_stall;

    modexp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Multiply issues acc * sq only for a set exponent bit; square issues sq * sq.
    assign w_mm_req.start = (w_ctrl.issue_mul && r_exp[0]) || w_ctrl.issue_sqr;
    assign w_mm_req.dest  = w_ctrl.issue_sqr ? D_SQ : D_ACC;
    assign w_mm_a         = w_ctrl.issue_sqr ? r_sq : r_acc;

    modexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mm_req),
        .i_a      (w_mm_a),
        .i_b      (r_sq),
        .o_rsp    (w_mm_rsp),
        .o_result (w_mm_result)
    );

    // A 30-bit base is below twice the modulus: one subtraction reduces it.
    assign w_base_diff = {1'b0, i_base} - {1'b0, MODULUS};
    assign w_base_red  = w_base_diff[30] ? i_base : w_base_diff[29:0];

    // Working registers: load, exponent shift and multiplier write-back.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_acc <= 30'd1;
            r_sq  <= w_base_red;
            r_exp <= i_invert ? INV_EXPONENT : i_exponent;
        end else begin
            if (w_ctrl.issue_sqr) begin
                r_exp <= r_exp >> 1;
            end
            if (w_mm_rsp.done) begin
                if (w_mm_rsp.dest == D_SQ) begin
                    r_sq <= w_mm_result;
                end else begin
                    r_acc <= w_mm_result;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.put) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.put) begin
            r_power_result <= r_acc;
        end
    end

    assign o_stall        = !w_ctrl.in_ready;
    assign o_valid        = r_out_valid;
    assign o_power_result = r_power_result;

endmodule

`default_nettype wire

FILE: rtl/modexp_mulmod.sv
// ============================================================================
// Modular multiplier
// Four-stage pipelined multiply and Barrett reduction modulo the prime.
// Operands must be below the modulus; the result is fully reduced.
// ============================================================================
`default_nettype none

module modexp_mulmod (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire modexp_pkg::t_mm_req i_req,
    input  wire logic [29:0]         i_a,
    input  wire logic [29:0]         i_b,
    output modexp_pkg::t_mm_rsp      o_rsp,
    output logic [29:0]              o_result
);
    import modexp_pkg::*;

    logic        r_v1, r_v2, r_v3;
    t_dest       r_d1, r_d2, r_d3;
    logic [59:0] r_p1, r_p2;
    logic [31:0] r_p3;
    logic [61:0] r_q2;
    logic [31:0] r_t3;

    logic [59:0] w_prod;
    logic [61:0] w_q2;
    logic [30:0] w_q3;
    logic [60:0] w_t;
    logic [31:0] w_r;
    logic [32:0] w_r1;
    logic [32:0] w_r2;

    // Stage 1 forms the full product, stage 2 the quotient estimate,
    // stage 3 the estimate times the modulus.
    assign w_prod = 60'(i_a) * 60'(i_b);
    assign w_q2   = 62'(r_p1[59:29]) * 62'(BARRETT_MU);
    assign w_q3   = r_q2[61:31];
    assign w_t    = 61'(w_q3) * 61'(MODULUS);

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload of the pipeline.
    always_ff @(posedge i_clk) begin
        r_d1 <= i_req.dest;
        r_p1 <= w_prod;
        r_d2 <= r_d1;
        r_p2 <= r_p1;
        r_q2 <= w_q2;
        r_d3 <= r_d2;
        r_p3 <= r_p2[31:0];
        r_t3 <= w_t[31:0];
    end

    // Stage 4: the remainder is below three times the modulus, so at most
    // two subtractions of the modulus bring it into range.
    assign w_r  = r_p3 - r_t3;
    assign w_r1 = {1'b0, w_r} - 33'(MODULUS);
    assign w_r2 = {1'b0, w_r} - {1'b0, MODULUS_X2};

    always_comb begin
        if (!w_r2[32]) begin
            o_result = w_r2[29:0];
        end else if (!w_r1[32]) begin
            o_result = w_r1[29:0];
        end else begin
            o_result = w_r[29:0];
        end
    end

    assign o_rsp.busy = r_v1 | r_v2 | r_v3;
    assign o_rsp.done = r_v3;
    assign o_rsp.dest = r_d3;

endmodule

`default_nettype wire

FILE: rtl/modexp_seq.sv
// ============================================================================
// Microcode sequencer
// Step counter that reads the control table, holds on its wait condition and
// branches on the exponent, driving the datapath strobes.
// ============================================================================
`default_nettype none

module modexp_seq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire modexp_pkg::t_seq_stat i_stat,
    output modexp_pkg::t_seq_ctrl      o_ctrl
);
    import modexp_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_ucode w_cw;
    logic   w_hold;

    assign w_cw = ucode_rom(r_step);

    // Hold the current step until its wait condition clears.
    always_comb begin
        case (w_cw.hold_on)
            H_NONE:   w_hold = 1'b0;
            H_INPUT:  w_hold = !i_stat.in_valid;
            H_BUSY:   w_hold = i_stat.busy;
            H_OUTPUT: w_hold = !i_stat.out_free;
            default:  w_hold = 1'b0;
        endcase
    end

    // Next step and datapath strobes.
    always_comb begin
        n_step = r_step;
        if (!w_hold) begin
            case (w_cw.cond)
                C_NEXT:     n_step = r_step + 3'd1;
                C_JUMP:     n_step = w_cw.target;
                C_EXP_ZERO: n_step = i_stat.exp_zero ? w_cw.target : r_step + 3'd1;
                default:    n_step = STEP_LOAD;
            endcase
        end
        o_ctrl.in_ready  = (w_cw.op == U_LOAD);
        o_ctrl.load      = (w_cw.op == U_LOAD) && !w_hold;
        o_ctrl.issue_mul = (w_cw.op == U_MUL) && !w_hold;
        o_ctrl.issue_sqr = (w_cw.op == U_SQR) && !w_hold;
        o_ctrl.put       = (w_cw.op == U_PUT) && !w_hold;
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/modexp_checker.sv
// ============================================================================
// Modular exponentiation checker
// Port-level properties of the block, attached to the top level by bind.
// ============================================================================
`default_nettype none

module modexp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [29:0] o_power_result
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_power_result))
        else $error("stalled result changed or dropped");

    // An accepted request keeps the input side stalled after it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall ##1 o_stall)
        else $error("request accepted while previous one still in work");

    // A new result appears only while a request is in work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a request in work");

endmodule

bind modular_exponentiation modexp_checker u_checker (.*);

`default_nettype wire
